// File: rtl/small_matrix_multiply_macros.svh
// Assertion macros for the small matrix multiply block
`ifndef SMALL_MATRIX_MULTIPLY_MACROS_SVH
`define SMALL_MATRIX_MULTIPLY_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, checked on clk, off while rst_n is low
`define SMM_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on clk, off while rst_n is low
`define SMM_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define SMM_ASSERT_IMP(lbl, ante, cons, msg)
`define SMM_ASSERT_NXT(lbl, ante, cons, msg)

`endif

`endif

// File: rtl/smm_pkg.sv
// Shared types, codes and constants of the small matrix multiply block
package smm_pkg;

  localparam int MAX_DIM_DEF   = 8;
  localparam int ELEM_BITS_DEF = 16;

  localparam int REQ_W  = 2;
  localparam int IDX_W  = 3;
  localparam int VAL_W  = 16;
  localparam int OUT_W  = 35;
  localparam int DIM_W  = 4;

  localparam int APB_ADDR_W = 4;
  localparam int APB_DATA_W = 32;

  // request codes
  localparam logic [REQ_W-1:0] REQ_WRITE_A = 2'd0;
  localparam logic [REQ_W-1:0] REQ_WRITE_B = 2'd1;
  localparam logic [REQ_W-1:0] REQ_RUN     = 2'd2;

  // register indexes
  localparam logic [1:0] REG_ROWS_OF_A  = 2'd0;
  localparam logic [1:0] REG_INNER_SIZE = 2'd1;
  localparam logic [1:0] REG_COLS_OF_B  = 2'd2;

  localparam logic [DIM_W-1:0] DIM_RESET = 4'd8;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MAC,
    ST_DRAIN,
    ST_EMIT
  } ctrl_state_t;

  // clamped dimensions, each 1..MAX_DIM
  typedef struct packed {
    logic [DIM_W-1:0] m;
    logic [DIM_W-1:0] k;
    logic [DIM_W-1:0] n;
  } dims_t;

  typedef struct packed {
    logic             wr_a;
    logic             wr_b;
    logic             issue;
    logic             acc_clear;
    logic             emit;
    logic             last;
    logic [IDX_W-1:0] row_i;
    logic [IDX_W-1:0] col_j;
    logic [IDX_W-1:0] inner_t;
  } dp_cmd_t;

  typedef struct packed {
    logic out_busy;
  } dp_status_t;

endpackage

// File: rtl/smm_if.sv
// Request and result channel interfaces
interface smm_req_if
  import smm_pkg::*;
  ();
  logic                    valid;
  logic                    ready;
  logic [REQ_W-1:0]        req_type;
  logic [IDX_W-1:0]        elem_row;
  logic [IDX_W-1:0]        elem_col;
  logic signed [VAL_W-1:0] elem_value;

  modport source (output valid, req_type, elem_row, elem_col, elem_value, input ready);
  modport sink   (input valid, req_type, elem_row, elem_col, elem_value, output ready);
endinterface

interface smm_res_if
  import smm_pkg::*;
  ();
  logic                    valid;
  logic                    ready;
  logic [IDX_W-1:0]        out_row;
  logic [IDX_W-1:0]        out_col;
  logic signed [OUT_W-1:0] out_value;
  logic                    last_flag;

  modport source (output valid, out_row, out_col, out_value, last_flag, input ready);
  modport sink   (input valid, out_row, out_col, out_value, last_flag, output ready);
endinterface

// File: rtl/smm_cfg.sv
// APB register file with dimension clamping
module smm_cfg
  import smm_pkg::*;
#(
  parameter int MAX_DIM = MAX_DIM_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  output dims_t                 dims
);

  localparam logic [DIM_W-1:0] DIM_MAX = DIM_W'(MAX_DIM);

  logic [DIM_W-1:0] rows_r, inner_r, cols_r;
  logic             wr_en;
  logic [1:0]       reg_idx;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
    logic [DIM_W-1:0] r;
    if (v == '0) begin
      r = DIM_W'(1);
    end else if (v > DIM_MAX) begin
      r = DIM_MAX;
    end else begin
      r = v;
    end
    return r;
  endfunction

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign wr_en   = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r  <= DIM_RESET;
      inner_r <= DIM_RESET;
      cols_r  <= DIM_RESET;
    end else if (wr_en) begin
      case (reg_idx)
        REG_ROWS_OF_A:  rows_r  <= pwdata[DIM_W-1:0];
        REG_INNER_SIZE: inner_r <= pwdata[DIM_W-1:0];
        REG_COLS_OF_B:  cols_r  <= pwdata[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_ROWS_OF_A:  prdata = APB_DATA_W'(rows_r);
      REG_INNER_SIZE: prdata = APB_DATA_W'(inner_r);
      REG_COLS_OF_B:  prdata = APB_DATA_W'(cols_r);
      default:        prdata = '0;
    endcase
  end

  assign dims.m = clamp_dim(rows_r);
  assign dims.k = clamp_dim(inner_r);
  assign dims.n = clamp_dim(cols_r);

endmodule

// File: rtl/smm_datapath.sv
// Element stores, multiplier, accumulator and result register
module smm_datapath
  import smm_pkg::*;
#(
  parameter int MAX_DIM   = MAX_DIM_DEF,
  parameter int ELEM_BITS = ELEM_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  dp_cmd_t                 cmd,
  input  dims_t                   dims,
  input  logic [IDX_W-1:0]        elem_row,
  input  logic [IDX_W-1:0]        elem_col,
  input  logic signed [VAL_W-1:0] elem_value,
  input  logic                    out_ready,
  output logic                    out_valid,
  output logic [IDX_W-1:0]        out_row,
  output logic [IDX_W-1:0]        out_col,
  output logic signed [OUT_W-1:0] out_value,
  output logic                    last_flag,
  output dp_status_t              status
);

  localparam int DEPTH  = MAX_DIM * MAX_DIM;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int PROD_W = 2 * ELEM_BITS;
  localparam int WIDE_W = (PROD_W > OUT_W) ? PROD_W : OUT_W;

  logic signed [ELEM_BITS-1:0] mem_a [DEPTH];
  logic signed [ELEM_BITS-1:0] mem_b [DEPTH];
  logic [DEPTH-1:0]            vld_a_r, vld_b_r;

  logic signed [ELEM_BITS-1:0] wr_val;
  logic [ADDR_W-1:0]           wr_addr, rd_addr_a, rd_addr_b;
  logic                        wr_ok_a, wr_ok_b;

  logic signed [ELEM_BITS-1:0] a_q_r, b_q_r;
  logic                        a_qv_r, b_qv_r;
  logic                        s1_vld_r, s2_vld_r;
  logic signed [ELEM_BITS-1:0] op_a, op_b;
  logic signed [PROD_W-1:0]    prod_r;
  logic signed [WIDE_W-1:0]    prod_wide;
  logic [OUT_W-1:0]            acc_r;

  logic                        out_valid_r;
  logic [IDX_W-1:0]            out_row_r, out_col_r;
  logic [OUT_W-1:0]            out_value_r;
  logic                        last_r;

  // value wrapped or sign-extended to the element width
  assign wr_val  = ELEM_BITS'(elem_value);
  assign wr_addr = ADDR_W'(elem_row * MAX_DIM + elem_col);
  assign wr_ok_a = cmd.wr_a && (DIM_W'(elem_row) < dims.m) && (DIM_W'(elem_col) < dims.k);
  assign wr_ok_b = cmd.wr_b && (DIM_W'(elem_row) < dims.k) && (DIM_W'(elem_col) < dims.n);

  assign rd_addr_a = ADDR_W'(cmd.row_i * MAX_DIM + cmd.inner_t);
  assign rd_addr_b = ADDR_W'(cmd.inner_t * MAX_DIM + cmd.col_j);

  always_ff @(posedge clk) begin
    if (wr_ok_a) begin
      mem_a[wr_addr] <= wr_val;
    end
    if (wr_ok_b) begin
      mem_b[wr_addr] <= wr_val;
    end
    a_q_r  <= mem_a[rd_addr_a];
    b_q_r  <= mem_b[rd_addr_b];
  end

  // entries never written read as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_a_r <= '0;
      vld_b_r <= '0;
      a_qv_r  <= 1'b0;
      b_qv_r  <= 1'b0;
    end else begin
      if (wr_ok_a) begin
        vld_a_r[wr_addr] <= 1'b1;
      end
      if (wr_ok_b) begin
        vld_b_r[wr_addr] <= 1'b1;
      end
      a_qv_r <= vld_a_r[rd_addr_a];
      b_qv_r <= vld_b_r[rd_addr_b];
    end
  end

  assign op_a = a_qv_r ? a_q_r : '0;
  assign op_b = b_qv_r ? b_q_r : '0;
  assign prod_wide = WIDE_W'(prod_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= cmd.issue;
      s2_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= op_a * op_b;
    if (cmd.acc_clear) begin
      acc_r <= '0;
    end else if (s2_vld_r) begin
      acc_r <= acc_r + prod_wide[OUT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_row_r   <= cmd.row_i;
      out_col_r   <= cmd.col_j;
      out_value_r <= acc_r;
      last_r      <= cmd.last;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_row         = out_row_r;
  assign out_col         = out_col_r;
  assign out_value       = $signed(out_value_r);
  assign last_flag       = last_r;
  assign status.out_busy = out_valid_r;

endmodule

// File: rtl/smm_ctrl.sv
// Request decode and run sequencer
`include "small_matrix_multiply_macros.svh"

module smm_ctrl
  import smm_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic [REQ_W-1:0] req_type,
  output logic             in_ready,
  input  logic             out_ready,
  input  dims_t            dims,
  input  dp_status_t       status,
  output dp_cmd_t          cmd
);

  ctrl_state_t      state_r, state_nxt;
  logic [IDX_W-1:0] i_r, i_nxt, j_r, j_nxt, t_r, t_nxt;
  logic             drain_r, drain_nxt;
  logic             in_xfer;
  logic             i_end, j_end, t_end, last_elem, can_emit;
  logic [DIM_W-1:0] t_ext;

  assign t_ext     = DIM_W'(t_r);
  assign i_end     = (DIM_W'(i_r) + DIM_W'(1)) == dims.m;
  assign j_end     = (DIM_W'(j_r) + DIM_W'(1)) == dims.n;
  assign t_end     = (t_ext + DIM_W'(1)) == dims.k;
  assign last_elem = i_end && j_end;
  assign can_emit  = !status.out_busy || out_ready;
  assign in_xfer   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      i_r     <= '0;
      j_r     <= '0;
      t_r     <= '0;
      drain_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      i_r     <= i_nxt;
      j_r     <= j_nxt;
      t_r     <= t_nxt;
      drain_r <= drain_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    t_nxt         = t_r;
    drain_nxt     = drain_r;
    in_ready      = 1'b0;
    cmd           = '0;
    cmd.row_i     = i_r;
    cmd.col_j     = j_r;
    cmd.inner_t   = t_r;
    cmd.last      = last_elem;

    case (state_r)
      ST_IDLE: begin
        // ready is high here, so valid alone marks a transfer
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.wr_a = (req_type == REQ_WRITE_A);
          cmd.wr_b = (req_type == REQ_WRITE_B);
          if (req_type == REQ_RUN) begin
            cmd.acc_clear = 1'b1;
            i_nxt         = '0;
            j_nxt         = '0;
            t_nxt         = '0;
            state_nxt     = ST_MAC;
          end
        end
      end
      ST_MAC: begin
        cmd.issue = 1'b1;
        if (t_end) begin
          t_nxt     = '0;
          drain_nxt = 1'b0;
          state_nxt = ST_DRAIN;
        end else begin
          t_nxt = t_r + IDX_W'(1);
        end
      end
      ST_DRAIN: begin
        // two stages (read, multiply) before the last product lands
        drain_nxt = 1'b1;
        if (drain_r) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (can_emit) begin
          cmd.emit      = 1'b1;
          cmd.acc_clear = 1'b1;
          if (last_elem) begin
            state_nxt = ST_IDLE;
          end else begin
            state_nxt = ST_MAC;
            if (j_end) begin
              j_nxt = '0;
              i_nxt = i_r + IDX_W'(1);
            end else begin
              j_nxt = j_r + IDX_W'(1);
            end
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  `SMM_ASSERT_IMP(a_emit_has_room, cmd.emit, !status.out_busy || out_ready, "emit onto a full output register")
  `SMM_ASSERT_NXT(a_run_starts, in_xfer && (req_type == REQ_RUN), state_r == ST_MAC, "run transfer did not start the sequencer")
  `SMM_ASSERT_IMP(a_inner_in_range, state_r == ST_MAC, t_ext < dims.k, "inner index beyond inner size")
  `SMM_ASSERT_NXT(a_last_ends_run, cmd.emit && cmd.last, state_r == ST_IDLE, "run did not end after its last element")

endmodule

// File: rtl/small_matrix_multiply.sv
// Top level of the small matrix multiply block
//
// Computes C = A x B on signed ELEM_BITS-bit elements held in two on-chip stores of
// MAX_DIM x MAX_DIM entries, both reading as zero after reset. A request transfer with
// req_type 0 or 1 writes one element of A or B at (elem_row, elem_col); writes
// outside the configured dimensions and req_type 3 are dropped, and none of these yields a
// result. req_type 2 runs the multiply and emits every element of C in row-major order, with
// last_flag on the final one; out_value is the exact dot product, kept to 35 bits. Each result
// element runs its inner-dimension multiply-accumulates in turn through the shared multiplier,
// lets the store read and multiply stages drain, and then loads the output register once it
// has room. Computation of the next element overlaps a result that still waits
// in the output register. The request channel is held off for the whole run. Dimensions
// are set over APB at byte addresses 0 (rows_of_a), 4 (inner_size) and 8 (cols_of_b),
// each 4 bits, reset 8; a 0 acts as 1 and a value above MAX_DIM acts as MAX_DIM. Write them
// only while the block is idle.
module small_matrix_multiply
  import smm_pkg::*;
#(
  parameter int MAX_DIM   = MAX_DIM_DEF,
  parameter int ELEM_BITS = ELEM_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  smm_req_if.sink               in_req,
  smm_res_if.source             out_res,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  dims_t      dims;
  dp_cmd_t    cmd;
  dp_status_t status;
  logic       in_ready;

  // register file, clamped dimensions out
  smm_cfg #(
    .MAX_DIM (MAX_DIM)
  ) u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .dims    (dims)
  );

  // sequencer: decodes request transfers, walks i, j and the inner index
  smm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_req.valid),
    .req_type  (in_req.req_type),
    .in_ready  (in_ready),
    .out_ready (out_res.ready),
    .dims      (dims),
    .status    (status),
    .cmd       (cmd)
  );

  assign in_req.ready = in_ready;

  // stores, multiply-accumulate pipe and result register
  smm_datapath #(
    .MAX_DIM   (MAX_DIM),
    .ELEM_BITS (ELEM_BITS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .dims       (dims),
    .elem_row   (in_req.elem_row),
    .elem_col   (in_req.elem_col),
    .elem_value (in_req.elem_value),
    .out_ready  (out_res.ready),
    .out_valid  (out_res.valid),
    .out_row    (out_res.out_row),
    .out_col    (out_res.out_col),
    .out_value  (out_res.out_value),
    .last_flag  (out_res.last_flag),
    .status     (status)
  );

endmodule
